/* rtl/tmba_pkg.sv */
// tmba_pkg: shared types and constants of the trimmed-mean block averager.
// No dependencies; imported by tmba_window, tmba_divider and the top level.
`default_nettype none

package tmba_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned VALUE_BITS  = 28;
  localparam int unsigned GAIN_BITS   = 16;
  localparam int unsigned BLEN_BITS   = 16;
  localparam int unsigned PROD_BITS   = VALUE_BITS + GAIN_BITS;
  localparam int unsigned DVS_BITS    = 16;
  localparam int unsigned ITER_BITS   = 6;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 16'd1133;
  localparam logic [BLEN_BITS-1:0]  BLEN_RESET = 16'd8000;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX  = {VALUE_BITS{1'b1}};

  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_BLEN = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [PROD_BITS-1:0]  dividend;
    logic [DVS_BITS-1:0]   divisor;
    logic [ITER_BITS-1:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [PROD_BITS-1:0]  quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/tmba_window.sv */
// tmba_window: sample ring window, synchronous memory with registered read,
// per-entry valid bits (unwritten entries read as zero) and write slot. Uses tmba_pkg.
`default_nettype none

module tmba_window #(
  parameter int unsigned WINDOW_LEN = 12,
  parameter int unsigned AW         = $clog2(WINDOW_LEN)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_en_i,
  input  wire logic [tmba_pkg::SAMPLE_BITS-1:0] wr_data_i,
  input  wire logic                             rd_en_i,
  input  wire logic [AW-1:0]                    rd_addr_i,
  output logic      [tmba_pkg::SAMPLE_BITS-1:0] rd_data_o
);
  import tmba_pkg::*;

  logic [SAMPLE_BITS-1:0] mem_q [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [WINDOW_LEN-1:0]  vld_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          slot_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      slot_q   <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == AW'(WINDOW_LEN - 1)) ? '0 : slot_q + AW'(1);
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* rtl/tmba_divider.sv */
// tmba_divider: restoring radix-2 divider, one quotient bit per cycle.
// Dividend is top-aligned by the caller; runs for the requested bit count. Uses tmba_pkg.
`default_nettype none

module tmba_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tmba_pkg::div_req_t req_i,
  output tmba_pkg::div_rsp_t      rsp_o
);
  import tmba_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [ITER_BITS-1:0] cnt_q;
  logic [DVS_BITS-1:0]  rem_q;
  logic [DVS_BITS-1:0]  dvs_q;
  logic [PROD_BITS-1:0] quo_q;

  logic [DVS_BITS:0]    trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - ITER_BITS'(1);
        if (cnt_q == ITER_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? DVS_BITS'(trial - {1'b0, dvs_q}) : trial[DVS_BITS-1:0];
      quo_q <= {quo_q[PROD_BITS-2:0], fits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/trimmed_mean_block_averager_unit.sv */
// trimmed_mean_block_averager_unit: top level; tick sequencer, block accumulator,
// config registers, output register. Uses tmba_pkg, tmba_window, tmba_divider.
//
// Input channel (in_valid_i/in_ready_o, cmd_i, sample_i): a sample transfer
// (cmd 0) writes the window and yields no result. A tick transfer
// (cmd 1) walks the window memory one entry per cycle (sum, min, max), then
// divides sum - max - min by WINDOW_LEN - 2 with a constant reciprocal multiply.
// After the walk and the divide come the accumulate and the output load.
// A tick that closes a block adds a multiply and a 44-bit serial divide by
// block_length before the output load. One item is in work at a time;
// in_ready_o is high only while the sequencer is idle, so the next transfer
// after a tick comes at the earliest in the cycle after its result is loaded.
// Output channel (out_valid_o/out_ready_i): one result per tick, held in an
// output register; samples are still taken while a result waits, and a tick
// that finishes while the receiver stalls waits for the register to free.
// Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once and
// must be made only while the block is idle; the block does not enforce this.
// Reset clears the window (valid bits), sums, counters and the held value, and
// loads gain 1133 and block length 8000; no clearing pass is needed.
`default_nettype none

module trimmed_mean_block_averager_unit #(
  parameter int unsigned WINDOW_LEN = 12
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              cmd_i,
  input  wire logic [tmba_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [tmba_pkg::SAMPLE_BITS-1:0]  trimmed_mean_o,
  output logic                                   block_done_o,
  output logic      [tmba_pkg::VALUE_BITS-1:0]   block_value_o,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_index_i,
  input  wire logic [15:0]                       cfg_wdata_i
);
  import tmba_pkg::*;

  localparam int unsigned AW       = $clog2(WINDOW_LEN);
  localparam int unsigned CW       = $clog2(WINDOW_LEN + 1);
  localparam int unsigned MEAN_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned MEAN_DIV = WINDOW_LEN - 2;
  localparam int unsigned MEAN_SH  = MEAN_W + $clog2(MEAN_DIV);
  localparam int unsigned RCP_W    = MEAN_W + 1;
  localparam int unsigned MPROD_W  = MEAN_W + RCP_W;
  // exact floor divide for any numerator below 2^MEAN_W
  localparam logic [RCP_W-1:0] MEAN_RCP =
    RCP_W'(((64'd1 << MEAN_SH) + 64'(MEAN_DIV) - 64'd1) / 64'(MEAN_DIV));

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MEAN, S_ACC, S_MUL, S_BSTART, S_BDIV, S_OUT
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          scan_cnt_q;
  logic [MEAN_W-1:0]      sum_q;
  logic [SAMPLE_BITS-1:0] lo_q;
  logic [SAMPLE_BITS-1:0] hi_q;
  logic [SAMPLE_BITS-1:0] mean_q;
  logic [VALUE_BITS-1:0]  bsum_q;
  logic [BLEN_BITS-1:0]   tick_q;
  logic [VALUE_BITS-1:0]  held_q;
  logic                   done_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [BLEN_BITS-1:0]   blen_q;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_mean_q;
  logic                   out_done_q;
  logic [VALUE_BITS-1:0]  out_value_q;

  logic                   in_fire;
  logic                   out_load;
  logic                   win_rd_en;
  logic [SAMPLE_BITS-1:0] win_data;
  logic [MEAN_W-1:0]      mean_num;
  logic [MPROD_W-1:0]     mean_prod;
  logic [SAMPLE_BITS-1:0] mean_calc;
  logic [BLEN_BITS-1:0]   blen_eff;
  logic [VALUE_BITS-1:0]  bsum_new;
  logic [BLEN_BITS-1:0]   tick_new;
  logic [VALUE_BITS-1:0]  value_sat;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign win_rd_en = (state_q == S_SCAN) && (scan_cnt_q < CW'(WINDOW_LEN));

  tmba_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .AW         (AW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_fire && (cmd_i == CMD_SAMPLE)),
    .wr_data_i (sample_i),
    .rd_en_i   (win_rd_en),
    .rd_addr_i (scan_cnt_q[AW-1:0]),
    .rd_data_o (win_data)
  );

  assign mean_num  = sum_q - MEAN_W'(hi_q) - MEAN_W'(lo_q);
  assign mean_prod = MPROD_W'(mean_num) * MPROD_W'(MEAN_RCP);
  assign mean_calc = mean_prod[MEAN_SH +: SAMPLE_BITS];
  assign blen_eff  = (blen_q == '0) ? BLEN_BITS'(1) : blen_q;

  always_comb begin
    div_req.start    = (state_q == S_BSTART);
    div_req.dividend = prod_q;
    div_req.divisor  = blen_eff;
    div_req.iters    = ITER_BITS'(PROD_BITS);
  end

  tmba_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign bsum_new  = bsum_q + VALUE_BITS'(mean_q);
  assign tick_new  = tick_q + BLEN_BITS'(1);
  assign value_sat = (div_rsp.quotient[PROD_BITS-1:VALUE_BITS] != '0) ? VALUE_MAX
                   : div_rsp.quotient[VALUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      blen_q <= BLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAIN: gain_q <= cfg_wdata_i;
        CFG_BLEN: blen_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      sum_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mean_q      <= '0;
      bsum_q      <= '0;
      tick_q      <= '0;
      held_q      <= '0;
      done_q      <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_mean_q  <= '0;
      out_done_q  <= 1'b0;
      out_value_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && (cmd_i == CMD_TICK)) begin
            scan_cnt_q <= '0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
          if (scan_cnt_q == CW'(1)) begin
            sum_q <= MEAN_W'(win_data);
            lo_q  <= win_data;
            hi_q  <= win_data;
          end else if (scan_cnt_q != '0) begin
            sum_q <= sum_q + MEAN_W'(win_data);
            if (win_data < lo_q) begin
              lo_q <= win_data;
            end
            if (win_data > hi_q) begin
              hi_q <= win_data;
            end
          end
          if (scan_cnt_q == CW'(WINDOW_LEN)) begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean_q  <= mean_calc;
          state_q <= S_ACC;
        end
        S_ACC: begin
          bsum_q <= bsum_new;
          if (tick_new >= blen_eff) begin
            tick_q  <= '0;
            state_q <= S_MUL;
          end else begin
            tick_q  <= tick_new;
            done_q  <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_MUL: begin
          prod_q  <= PROD_BITS'(bsum_q) * PROD_BITS'(gain_q);
          state_q <= S_BSTART;
        end
        S_BSTART: begin
          state_q <= S_BDIV;
        end
        S_BDIV: begin
          if (div_rsp.done) begin
            held_q  <= value_sat;
            bsum_q  <= '0;
            done_q  <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_mean_q  <= mean_q;
            out_done_q  <= done_q;
            out_value_q <= held_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trimmed_mean_o = out_mean_q;
  assign block_done_o   = out_done_q;
  assign block_value_o  = out_value_q;

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_BDIV))
    else $error("divider finished outside a divide state");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_cnt_q <= CW'(WINDOW_LEN)))
    else $error("window walk ran past the last entry");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_OUT))
    else $error("result raised without the output state");

endmodule

`default_nettype wire

/* tb/sv/tmba_checker.sv */
`timescale 1ns / 100ps
// tmba_checker: passive scoreboard for the trimmed-mean block averager. It keeps its own copy
// of the window, block accumulator and config, predicts each tick result and compares it.
// Depends on tmba_pkg for widths, command codes and config indexes.

module tmba_checker #(
  parameter int unsigned WINDOW_LEN = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [tmba_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [tmba_pkg::SAMPLE_BITS-1:0]  trimmed_mean_o,
  input  logic                              block_done_o,
  input  logic [tmba_pkg::VALUE_BITS-1:0]   block_value_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [15:0]                       cfg_wdata_i,
  output int                                mismatch_count_o,
  output int                                pending_count_o
);
  import tmba_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] trimmed_mean;
    logic                   block_done;
    logic [VALUE_BITS-1:0]  block_value;
  } tick_result_t;

  logic [SAMPLE_BITS-1:0] window_q [WINDOW_LEN];
  int unsigned            slot_q;
  logic [VALUE_BITS-1:0]  block_sum_q;
  logic [BLEN_BITS-1:0]   tick_count_q;
  logic [VALUE_BITS-1:0]  held_value_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [BLEN_BITS-1:0]   blen_q;
  tick_result_t           tick_results_due [$];
  int                     mismatches = 0;

  function automatic logic [SAMPLE_BITS-1:0] window_trimmed_mean();
    logic [31:0]            total;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    total = '0;
    lo    = window_q[0];
    hi    = window_q[0];
    for (int k = 0; k < WINDOW_LEN; k++) begin
      total = total + 32'(window_q[k]);
      if (window_q[k] < lo) lo = window_q[k];
      if (window_q[k] > hi) hi = window_q[k];
    end
    return SAMPLE_BITS'((total - 32'(hi) - 32'(lo)) / 32'(WINDOW_LEN - 2));
  endfunction

  task automatic accumulate_tick();
    tick_result_t         r;
    logic [BLEN_BITS-1:0] len;
    logic [PROD_BITS-1:0] product;
    logic [PROD_BITS-1:0] quotient;
    r.trimmed_mean = window_trimmed_mean();
    r.block_done   = 1'b0;
    block_sum_q    = block_sum_q + VALUE_BITS'(r.trimmed_mean);
    tick_count_q   = tick_count_q + 1'b1;
    len = (blen_q == '0) ? BLEN_BITS'(1) : blen_q;
    if (tick_count_q >= len) begin
      product  = PROD_BITS'(block_sum_q) * PROD_BITS'(gain_q);
      quotient = product / PROD_BITS'(len);
      held_value_q = (quotient > PROD_BITS'(VALUE_MAX)) ? VALUE_MAX
                                                        : quotient[VALUE_BITS-1:0];
      block_sum_q  = '0;
      tick_count_q = '0;
      r.block_done = 1'b1;
    end
    r.block_value = held_value_q;
    tick_results_due.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    tick_result_t due;
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN; k++) window_q[k] = '0;
      slot_q       = 0;
      block_sum_q  = '0;
      tick_count_q = '0;
      held_value_q = '0;
      gain_q       = GAIN_RESET;
      blen_q       = BLEN_RESET;
      tick_results_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_GAIN) gain_q = cfg_wdata_i;
        else blen_q = cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        if (tick_results_due.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches++;
        end else begin
          due = tick_results_due.pop_front();
          if (trimmed_mean_o !== due.trimmed_mean) begin
            $error("trimmed_mean: expected %0d, actual %0d", due.trimmed_mean, trimmed_mean_o);
            mismatches++;
          end
          if (block_done_o !== due.block_done) begin
            $error("block_done: expected %0d, actual %0d", due.block_done, block_done_o);
            mismatches++;
          end
          if (block_value_o !== due.block_value) begin
            $error("block_value: expected %0d, actual %0d", due.block_value, block_value_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (cmd_i == CMD_SAMPLE) begin
          window_q[slot_q] = sample_i;
          slot_q = (slot_q + 1 >= WINDOW_LEN) ? 0 : slot_q + 1;
        end else begin
          accumulate_tick();
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= tick_results_due.size();
  end

endmodule

/* tb/sv/trimmed_mean_block_averager_unit_tb.sv */
`timescale 1ns / 100ps
// trimmed_mean_block_averager_unit_tb: stimulus, config phases, receiver stalls and verdict.
// Instantiates trimmed_mean_block_averager_unit and tmba_checker; depends on tmba_pkg.

module trimmed_mean_block_averager_unit_tb;
  import tmba_pkg::*;

  localparam int unsigned WINDOW_LEN    = 12;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 140;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   cmd_i       = CMD_SAMPLE;
  logic [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                   out_ready_i = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_index_i = CFG_GAIN;
  logic [15:0]            cfg_wdata_i = '0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [SAMPLE_BITS-1:0] trimmed_mean_o;
  logic                   block_done_o;
  logic [VALUE_BITS-1:0]  block_value_o;

  int          mismatch_count;
  int          pending_count;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_left   = 0;

  trimmed_mean_block_averager_unit #(.WINDOW_LEN(WINDOW_LEN)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .sample_i,
    .out_valid_o, .out_ready_i, .trimmed_mean_o, .block_done_o, .block_value_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  tmba_checker #(.WINDOW_LEN(WINDOW_LEN)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .sample_i,
    .out_valid_o, .out_ready_i, .trimmed_mean_o, .block_done_o, .block_value_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sender: bursts of back-to-back transfers separated by random gaps
  task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    sample_i   <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_random_item();
    logic [SAMPLE_BITS-1:0] smp;
    int unsigned            pick;
    pick = $urandom_range(0, 19);
    smp  = SAMPLE_BITS'($urandom_range(0, 4095));
    if (pick == 0) smp = '0;
    else if (pick == 1) smp = '1;
    else if (pick < 4) smp = SAMPLE_BITS'($urandom_range(2000, 2100));
    send_item(($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_SAMPLE, smp);
  endtask

  // hold off until every tick result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] gain, input logic [15:0] blen);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_GAIN;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_index_i <= CFG_BLEN;
    cfg_wdata_i <= blen;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin : rx_pattern
    int unsigned pick;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_ready_i <= 1'b1;
        stall_left  <= $urandom_range(0, 29);
      end else if (pick < 7) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 5);
      end else if (pick == 7) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(14, 39);
      end else if (pick == 8) begin
        out_ready_i <= 1'b1;
        stall_left  <= $urandom_range(59, 199);
      end else begin
        out_ready_i <= ~out_ready_i;
        stall_left  <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    @(posedge clk_i);
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("FAIL trimmed_mean_block_averager_unit");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] gain;
    logic [15:0] blen;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared window under power-on config
    send_item(CMD_TICK, '1);
    drain();
    // full-scale window, largest block value, then low and mixed impulses
    write_config('1, 16'd1);
    repeat (WINDOW_LEN) send_item(CMD_SAMPLE, '1);
    send_item(CMD_TICK, '0);
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_TICK, '1);
    send_item(CMD_SAMPLE, 12'hAAA);
    send_item(CMD_SAMPLE, 12'h555);
    send_item(CMD_TICK, '0);
    drain();
    // zero block length acts as one
    write_config('0, '0);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '1);
    drain();
    // block length lowered mid-block, scaled value saturates
    write_config('1, '1);
    repeat (3) send_item(CMD_TICK, '0);
    drain();
    write_config('1, 16'd2);
    send_item(CMD_TICK, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          gain = GAIN_RESET;
          blen = BLEN_RESET;
        end
        1: begin
          gain = '1;
          blen = 16'd1;
        end
        2: begin
          gain = '0;
          blen = 16'd2;
        end
        3: begin
          gain = '1;
          blen = '1;
        end
        4: begin
          gain = 16'($urandom_range(0, 65535));
          blen = 16'd5;
        end
        default: begin
          gain = 16'($urandom_range(0, 65535));
          blen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(25, 400))
                                             : 16'($urandom_range(1, 24));
        end
      endcase
      write_config(gain, blen);
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS trimmed_mean_block_averager_unit");
    end else begin
      $display("FAIL trimmed_mean_block_averager_unit");
    end
    $finish;
  end

endmodule
